// ===== rtl/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants for the min-heap priority queue
// Holds the parameter defaults, the request and status codes, and the
// command/status structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    // Parameter defaults
    localparam int CAPACITY_DEF = 256;
    localparam int KEY_BITS_DEF = 32;
    localparam int ID_BITS_DEF  = 9;

    // Request opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic take;     // latch the incoming request
        logic up_rd;    // sift up: read parent, or place at root
        logic up_cmp;   // sift up: compare with parent and move
        logic rm_load;  // remove: capture root and last entry
        logic dn_rd;    // sift down: read children, or place at leaf
        logic dn_cmp;   // sift down: compare with smaller child and move
        logic emit;     // load the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic op_remove; // incoming request is a remove
        logic full;      // heap holds CAPACITY entries
        logic empty;     // heap holds no entries
        logic at_root;   // sift-up position is the root
        logic up_less;   // carried entry is less than its parent
        logic leaf;      // sift-down position has no children
        logic dn_less;   // smaller child is less than the carried entry
        logic out_free;  // output register can take a result
    } stat_t;

endpackage

// ===== rtl/mhpq_ram.sv =====
// ----------------------------------------------------------------------------
// mhpq_ram: heap entry store
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module mhpq_ram #(
    parameter int DEPTH = 256,
    parameter int DW    = 41,
    parameter int AW    = 8
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read ports
    always_ff @(posedge aclk) begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/mhpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mhpq_ctrl: request sequencer
// Walks one request through take, sift up or sift down, and result hand-off.
// ----------------------------------------------------------------------------
module mhpq_ctrl
    import mhpq_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP_RD  = 3'd1;
    localparam logic [2:0] S_UP_CMP = 3'd2;
    localparam logic [2:0] S_RM_LD  = 3'd3;
    localparam logic [2:0] S_DN_RD  = 3'd4;
    localparam logic [2:0] S_DN_CMP = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.take = 1'b1;
                    if (stat.op_remove) begin
                        state_next = stat.empty ? S_DONE : S_RM_LD;
                    end else begin
                        state_next = stat.full ? S_DONE : S_UP_RD;
                    end
                end
            end
            S_UP_RD: begin
                cmd.up_rd  = 1'b1;
                state_next = stat.at_root ? S_DONE : S_UP_CMP;
            end
            S_UP_CMP: begin
                cmd.up_cmp = 1'b1;
                state_next = stat.up_less ? S_UP_RD : S_DONE;
            end
            S_RM_LD: begin
                cmd.rm_load = 1'b1;
                state_next  = S_DN_RD;
            end
            S_DN_RD: begin
                cmd.dn_rd  = 1'b1;
                state_next = stat.leaf ? S_DONE : S_DN_CMP;
            end
            S_DN_CMP: begin
                cmd.dn_cmp = 1'b1;
                state_next = stat.dn_less ? S_DN_RD : S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_take_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |-> state_reg == S_IDLE)
        else $error("request taken outside idle");
    a_done_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> state_reg == S_IDLE)
        else $error("emit did not return to idle");
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one command active");
`endif

endmodule

// ===== rtl/mhpq_dp.sv =====
// ----------------------------------------------------------------------------
// mhpq_dp: heap datapath
// Entry count, sift position, carried entry, compares, result and output
// registers, and the entry store.
// ----------------------------------------------------------------------------
module mhpq_dp
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int ID_BITS  = ID_BITS_DEF,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic                s_opcode,
    input  logic [KEY_BITS-1:0] s_key,
    input  logic [ID_BITS-1:0]  s_node_id,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [KEY_BITS-1:0] m_out_key,
    output logic [ID_BITS-1:0]  m_out_node_id,
    output logic [CW-1:0]       m_count_after
);

    localparam int AW = $clog2(CAPACITY);
    localparam int DW = KEY_BITS + ID_BITS;
    localparam logic [CW-1:0] CAP_CW = CW'(CAPACITY);
    localparam logic [CW-1:0] ROOT   = CW'(1);

    // Heap position (1-based) to store address
    function automatic logic [AW-1:0] to_addr(input logic [CW:0] p);
        logic [CW:0] q;
        q = p - 1'b1;
        return q[AW-1:0];
    endfunction

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       pos_reg;
    logic [KEY_BITS-1:0] item_key_reg;
    logic [ID_BITS-1:0]  item_id_reg;
    logic [1:0]          res_status_reg;
    logic [KEY_BITS-1:0] res_key_reg;
    logic [ID_BITS-1:0]  res_id_reg;
    logic                m_valid_reg;
    logic [1:0]          m_status_reg;
    logic [KEY_BITS-1:0] m_out_key_reg;
    logic [ID_BITS-1:0]  m_out_node_id_reg;
    logic [CW-1:0]       m_count_after_reg;

    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    logic [DW-1:0] rdata_a;
    logic [DW-1:0] rdata_b;

    logic [KEY_BITS-1:0] key_a;
    logic [KEY_BITS-1:0] key_b;
    logic [CW:0]         pos_ext;
    logic [CW:0]         count_ext;
    logic [CW:0]         lpos;
    logic [CW:0]         rpos;
    logic [CW-1:0]       parent;
    logic                has_right;
    logic                pick_right;
    logic                b_lt_a;
    logic                a_lt_item;
    logic                b_lt_item;
    logic [DW-1:0]       child;
    logic [CW:0]         cpos;

    assign key_a     = rdata_a[DW-1:ID_BITS];
    assign key_b     = rdata_b[DW-1:ID_BITS];
    assign pos_ext   = {1'b0, pos_reg};
    assign count_ext = {1'b0, count_reg};
    assign lpos      = {pos_reg, 1'b0};
    assign rpos      = lpos + 1'b1;
    assign parent    = pos_reg >> 1;
    assign has_right = (rpos <= count_ext);

    // Child selection: the three compares run side by side
    assign b_lt_a     = (key_b < key_a);
    assign a_lt_item  = (key_a < item_key_reg);
    assign b_lt_item  = (key_b < item_key_reg);
    assign pick_right = has_right && b_lt_a;
    assign child      = pick_right ? rdata_b : rdata_a;
    assign cpos       = pick_right ? rpos : lpos;

    // Status to the controller
    always_comb begin
        stat           = '0;
        stat.op_remove = (s_opcode == OP_REMOVE);
        stat.full      = (count_reg == CAP_CW);
        stat.empty     = (count_reg == '0);
        stat.at_root   = (pos_reg == ROOT);
        stat.up_less   = (item_key_reg < key_a);
        stat.leaf      = (lpos > count_ext);
        stat.dn_less   = pick_right ? b_lt_item : a_lt_item;
        stat.out_free  = !m_valid_reg || m_ready;
    end

    // Store addressing and writes
    always_comb begin
        we      = 1'b0;
        waddr   = to_addr(pos_ext);
        wdata   = {item_key_reg, item_id_reg};
        raddr_a = to_addr({1'b0, parent});
        raddr_b = to_addr({1'b0, parent});
        if (cmd.take) begin
            raddr_a = to_addr({1'b0, ROOT});
            raddr_b = to_addr(count_ext);
        end
        if (cmd.dn_rd) begin
            raddr_a = to_addr(lpos);
            raddr_b = has_right ? to_addr(rpos) : to_addr(lpos);
        end
        if (cmd.up_rd && stat.at_root) begin
            we = 1'b1;
        end
        if (cmd.up_cmp) begin
            we = 1'b1;
            if (stat.up_less) begin
                wdata = rdata_a;
            end
        end
        if (cmd.dn_rd && stat.leaf) begin
            we = 1'b1;
        end
        if (cmd.dn_cmp) begin
            we = 1'b1;
            if (stat.dn_less) begin
                wdata = child;
            end
        end
    end

    // Count, position and carried entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.take) begin
            if (stat.op_remove && !stat.empty) begin
                count_reg <= count_reg - 1'b1;
            end else if (!stat.op_remove && !stat.full) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            item_key_reg <= s_key;
            item_id_reg  <= s_node_id;
            pos_reg      <= stat.op_remove ? ROOT : count_reg + 1'b1;
        end
        if (cmd.rm_load) begin
            item_key_reg <= rdata_b[DW-1:ID_BITS];
            item_id_reg  <= rdata_b[ID_BITS-1:0];
        end
        if (cmd.up_cmp && stat.up_less) begin
            pos_reg <= parent;
        end
        if (cmd.dn_cmp && stat.dn_less) begin
            pos_reg <= cpos[CW-1:0];
        end
    end

    // Pending result
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            res_key_reg <= '0;
            res_id_reg  <= '0;
            if (stat.op_remove) begin
                res_status_reg <= stat.empty ? ST_EMPTY : ST_OK;
            end else begin
                res_status_reg <= stat.full ? ST_FULL : ST_OK;
            end
        end
        if (cmd.rm_load) begin
            res_key_reg <= key_a;
            res_id_reg  <= rdata_a[ID_BITS-1:0];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_status_reg      <= res_status_reg;
            m_out_key_reg     <= res_key_reg;
            m_out_node_id_reg <= res_id_reg;
            m_count_after_reg <= count_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_out_key     = m_out_key_reg;
    assign m_out_node_id = m_out_node_id_reg;
    assign m_count_after = m_count_after_reg;

    mhpq_ram #(
        .DEPTH (CAPACITY),
        .DW    (DW),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CW)
        else $error("entry count above capacity");
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg != ST_OK |->
            m_out_key_reg == '0 && m_out_node_id_reg == '0)
        else $error("rejected request carries an entry");
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg == ST_EMPTY |-> m_count_after_reg == '0)
        else $error("empty result with nonzero count");
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg == ST_FULL |-> m_count_after_reg == CAP_CW)
        else $error("full result below capacity");
    a_pos_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.up_cmp || cmd.dn_cmp || cmd.up_rd || cmd.dn_rd |->
            pos_reg != '0 && pos_reg <= CAP_CW)
        else $error("sift position out of range");
`endif

endmodule

// ===== rtl/min_heap_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// min_heap_priority_queue_top: binary min-heap priority queue
// Insert and remove-minimum on (key, node id) entries, root at position 1,
// one result per request with a status and the entry count afterwards.
// ----------------------------------------------------------------------------
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  request | s_valid s_ready s_opcode s_key s_node_id       | in
//  result  | m_valid m_ready m_status m_out_key             | out
//          | m_out_node_id m_count_after                    |
//
//  One request at a time; each level costs a store read and a compare/write
//  step. An insert climbs by parent read and compare/write steps; a remove
//  loads the root and last entry, then descends by child read and
//  compare/write steps; rejects go straight to the result hand-off.
//  Reset (aresetn low, synchronous) empties the heap; the store is not cleared.
//  A waiting result lets the next request in; it stalls only at its hand-off.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_top
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int ID_BITS  = ID_BITS_DEF,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    input  logic [KEY_BITS-1:0] s_key,
    input  logic [ID_BITS-1:0]  s_node_id,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [KEY_BITS-1:0] m_out_key,
    output logic [ID_BITS-1:0]  m_out_node_id,
    output logic [CW-1:0]       m_count_after
);

    cmd_t  cmd;
    stat_t stat;

    mhpq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mhpq_dp #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS),
        .ID_BITS  (ID_BITS),
        .CW       (CW)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_opcode      (s_opcode),
        .s_key         (s_key),
        .s_node_id     (s_node_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_out_key     (m_out_key),
        .m_out_node_id (m_out_node_id),
        .m_count_after (m_count_after)
    );

endmodule
